// ----- rtl/scrb_pkg.sv -----
`timescale 1ns / 1ps

package scrb_pkg;

  // default size of the register memory in bytes
  localparam int unsigned MEM_BYTES = 16;

  // command codes
  localparam logic [7:0] CMD_READ  = 8'h55;
  localparam logic [7:0] CMD_WRITE = 8'hAA;

  // longest read reply in beats
  localparam int unsigned REPLY_LIMIT = 16;
  localparam int unsigned CNT_W       = $clog2(REPLY_LIMIT + 1);

  typedef enum logic [3:0] {
    PH_CMD,
    PH_SIZE_HI,
    PH_SIZE_LO,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_DATA,
    PH_CALC,
    PH_FETCH,
    PH_SEND
  } phase_e;

endpackage

// ----- rtl/serial_command_register_bridge_unit.sv -----
`timescale 1ns / 1ps
// serial command register bridge: parses command frames from a byte stream
// header and write data bytes: one beat per cycle, no result
// read reply: after the fifth header byte the calc and fetch states (fetch skipped when empty),
//   then one beat per cycle while the receiver is ready, up to 16 beats, set by the single memory read port
// input is not taken while a reply is being sent
// reset: parser waits for a command byte, register memory reads as all zero

module serial_command_register_bridge_unit #(
  parameter int unsigned MemBytes = scrb_pkg::MEM_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // received bytes
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  // read reply
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] read_byte
  output logic       m_axis_tlast_o,   // is_last
  output logic       m_axis_tuser_o    // [0] clipped
);

  localparam int unsigned AddrW = $clog2(MemBytes);
  localparam int unsigned CntW  = scrb_pkg::CNT_W;

  // sequencer state
  scrb_pkg::phase_e phase_q, phase_d;

  // frame registers
  logic            kind_q, kind_d;       // 1 for a write frame
  logic [15:0]     size_q, size_d;
  logic [15:0]     start_q, start_d;
  logic [15:0]     dcnt_q, dcnt_d;       // write data bytes taken so far

  // reply registers
  logic [CntW-1:0]  rem_q, rem_d;        // beats still to send
  logic             clip_q, clip_d;
  logic             empty_q, empty_d;    // reply is a single zero beat
  logic [AddrW-1:0] ptr_q, ptr_d;

  // handshakes
  logic in_beat;
  logic out_beat;
  logic last_beat;

  // memory port
  logic             mem_wr_en;
  logic [AddrW-1:0] mem_wr_addr;
  logic             mem_rd_en;
  logic [AddrW-1:0] mem_rd_addr;
  logic [7:0]       mem_rd_data;

  // write address and reply length arithmetic
  logic [16:0]      wr_sum;
  logic             wr_hit;
  logic [15:0]      avail;
  logic [15:0]      take;
  logic [15:0]      count;
  logic             clip_calc;
  logic [15:0]      dcnt_inc;

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat  = m_axis_tvalid_o && m_axis_tready_i;
  assign last_beat = empty_q || (rem_q == CntW'(1));

  // address of the current write data byte, no wrap
  assign wr_sum   = {1'b0, start_q} + {1'b0, dcnt_q};
  assign wr_hit   = wr_sum < 17'(MemBytes);
  assign dcnt_inc = dcnt_q + 16'd1;

  // reply length: bytes left up to the memory end, then the reply limit
  always_comb begin
    avail     = (start_q < 16'(MemBytes)) ? (16'(MemBytes) - start_q) : 16'd0;
    take      = (size_q < avail) ? size_q : avail;
    clip_calc = (take != size_q);
    count     = take;
    if (take > 16'(scrb_pkg::REPLY_LIMIT)) begin
      count     = 16'(scrb_pkg::REPLY_LIMIT);
      clip_calc = 1'b1;
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      scrb_pkg::PH_CMD: begin
        if (in_beat && (s_axis_tdata_i == scrb_pkg::CMD_READ ||
                        s_axis_tdata_i == scrb_pkg::CMD_WRITE)) begin
          phase_d = scrb_pkg::PH_SIZE_HI;
        end
      end
      scrb_pkg::PH_SIZE_HI: if (in_beat) phase_d = scrb_pkg::PH_SIZE_LO;
      scrb_pkg::PH_SIZE_LO: if (in_beat) phase_d = scrb_pkg::PH_ADDR_HI;
      scrb_pkg::PH_ADDR_HI: if (in_beat) phase_d = scrb_pkg::PH_ADDR_LO;
      scrb_pkg::PH_ADDR_LO: begin
        if (in_beat) begin
          if (!kind_q) begin
            phase_d = scrb_pkg::PH_CALC;
          end else if (size_q == 16'd0) begin
            phase_d = scrb_pkg::PH_CMD;
          end else begin
            phase_d = scrb_pkg::PH_DATA;
          end
        end
      end
      scrb_pkg::PH_DATA: begin
        if (in_beat && dcnt_inc == size_q) begin
          phase_d = scrb_pkg::PH_CMD;
        end
      end
      scrb_pkg::PH_CALC: begin
        phase_d = (count == 16'd0) ? scrb_pkg::PH_SEND : scrb_pkg::PH_FETCH;
      end
      scrb_pkg::PH_FETCH: phase_d = scrb_pkg::PH_SEND;
      scrb_pkg::PH_SEND: begin
        if (out_beat && last_beat) begin
          phase_d = scrb_pkg::PH_CMD;
        end
      end
      default: phase_d = scrb_pkg::PH_CMD;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    kind_d      = kind_q;
    size_d      = size_q;
    start_d     = start_q;
    dcnt_d      = dcnt_q;
    rem_d       = rem_q;
    clip_d      = clip_q;
    empty_d     = empty_q;
    ptr_d       = ptr_q;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wr_sum[AddrW-1:0];
    mem_rd_en   = 1'b0;
    mem_rd_addr = ptr_q;
    case (phase_q)
      scrb_pkg::PH_CMD: begin
        s_axis_tready_o = 1'b1;
        if (in_beat) begin
          kind_d = (s_axis_tdata_i == scrb_pkg::CMD_WRITE);
        end
      end
      scrb_pkg::PH_SIZE_HI: begin
        s_axis_tready_o = 1'b1;
        if (in_beat) size_d = {s_axis_tdata_i, 8'h00};
      end
      scrb_pkg::PH_SIZE_LO: begin
        s_axis_tready_o = 1'b1;
        if (in_beat) size_d = {size_q[15:8], s_axis_tdata_i};
      end
      scrb_pkg::PH_ADDR_HI: begin
        s_axis_tready_o = 1'b1;
        if (in_beat) start_d = {s_axis_tdata_i, 8'h00};
      end
      scrb_pkg::PH_ADDR_LO: begin
        s_axis_tready_o = 1'b1;
        if (in_beat) begin
          start_d = {start_q[15:8], s_axis_tdata_i};
          dcnt_d  = 16'd0;
        end
      end
      scrb_pkg::PH_DATA: begin
        s_axis_tready_o = 1'b1;
        if (in_beat) begin
          // bytes past the memory end are taken and dropped
          mem_wr_en = wr_hit;
          dcnt_d    = dcnt_inc;
        end
      end
      scrb_pkg::PH_CALC: begin
        rem_d   = CntW'(count);
        clip_d  = clip_calc;
        empty_d = (count == 16'd0);
        ptr_d   = start_q[AddrW-1:0];
      end
      scrb_pkg::PH_FETCH: begin
        mem_rd_en = 1'b1;
      end
      scrb_pkg::PH_SEND: begin
        m_axis_tvalid_o = 1'b1;
        if (out_beat && !last_beat) begin
          // prefetch the next byte while this beat leaves
          ptr_d       = ptr_q + AddrW'(1);
          rem_d       = rem_q - CntW'(1);
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_d;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata_o = empty_q ? 8'h00 : mem_rd_data;
  assign m_axis_tlast_o = last_beat;
  assign m_axis_tuser_o = clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= scrb_pkg::PH_CMD;
      kind_q  <= 1'b0;
      size_q  <= 16'd0;
      start_q <= 16'd0;
      dcnt_q  <= 16'd0;
      rem_q   <= '0;
      clip_q  <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      size_q  <= size_d;
      start_q <= start_d;
      dcnt_q  <= dcnt_d;
      rem_q   <= rem_d;
      clip_q  <= clip_d;
      empty_q <= empty_d;
    end
  end

  // read pointer is payload, loaded before use
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
  end

  scrb_regmem #(
    .MemBytes (MemBytes),
    .AddrW    (AddrW)
  ) u_regmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (s_axis_tdata_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

endmodule

// ----- rtl/scrb_regmem.sv -----
`timescale 1ns / 1ps

module scrb_regmem #(
  parameter int unsigned MemBytes = scrb_pkg::MEM_BYTES,
  parameter int unsigned AddrW    = $clog2(MemBytes)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0]          mem_q [MemBytes];
  logic [MemBytes-1:0] valid_q;
  logic [7:0]          rd_data_q;

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : 8'h00;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- tb/tb_serial_command_register_bridge_unit.sv -----
`timescale 1ns / 1ps

module tb_serial_command_register_bridge_unit;

  localparam int unsigned MemN       = scrb_pkg::MEM_BYTES;
  localparam int unsigned CycleLimit = 400000;
  // reply starts after the header, let it drain
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       clip;
  } reply_beat_t;

  logic       clk;
  logic       rst_n;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  // mirror of the frame parser and the register memory
  scrb_pkg::phase_e rx_phase;
  logic             rx_is_write;
  logic [15:0]      rx_size;
  logic [15:0]      rx_addr;
  logic [15:0]      rx_wr_count;
  logic [7:0]       reg_mem [MemN];

  reply_beat_t reply_q[$];

  int unsigned error_cnt;
  int unsigned cycle_cnt;
  int unsigned parsed_cnt;  // beats that were not thrown away as unknown commands
  int unsigned gap_pct;     // chance of a sender pause before a beat
  int unsigned stall_pct;   // chance of a receiver stall on a cycle

  serial_command_register_bridge_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run time guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // advance the parser mirror by one received byte, queue any read reply;
  // returns 1 when the byte is dropped as an unknown command
  function automatic bit parse_rx_byte(input logic [7:0] b);
    int unsigned avail;
    int unsigned n;
    int unsigned start;
    int unsigned size;
    int unsigned waddr;
    logic        clip;
    avail = 0;
    case (rx_phase)
      scrb_pkg::PH_CMD: begin
        if (b == scrb_pkg::CMD_READ || b == scrb_pkg::CMD_WRITE) begin
          rx_is_write = (b == scrb_pkg::CMD_WRITE);
          rx_phase = scrb_pkg::PH_SIZE_HI;
        end else begin
          return 1'b1;
        end
      end
      scrb_pkg::PH_SIZE_HI: begin
        rx_size = {b, 8'h00};
        rx_phase = scrb_pkg::PH_SIZE_LO;
      end
      scrb_pkg::PH_SIZE_LO: begin
        rx_size[7:0] = b;
        rx_phase = scrb_pkg::PH_ADDR_HI;
      end
      scrb_pkg::PH_ADDR_HI: begin
        rx_addr = {b, 8'h00};
        rx_phase = scrb_pkg::PH_ADDR_LO;
      end
      scrb_pkg::PH_ADDR_LO: begin
        rx_addr[7:0] = b;
        rx_wr_count = '0;
        if (!rx_is_write) begin
          rx_phase = scrb_pkg::PH_CMD;
          start = rx_addr;
          size = rx_size;
          if (start < MemN) avail = MemN - start;
          n = (size < avail) ? size : avail;
          clip = (n < size);
          if (n > scrb_pkg::REPLY_LIMIT) begin
            n = scrb_pkg::REPLY_LIMIT;
            clip = 1'b1;
          end
          // nothing readable: a single zero beat
          if (n == 0) begin
            reply_q.push_back('{data: 8'h00, last: 1'b1, clip: clip});
          end else begin
            for (int unsigned k = 0; k < n; k++) begin
              reply_q.push_back('{data: reg_mem[start + k], last: (k + 1 == n), clip: clip});
            end
          end
        end else begin
          rx_phase = (rx_size == 0) ? scrb_pkg::PH_CMD : scrb_pkg::PH_DATA;
        end
      end
      scrb_pkg::PH_DATA: begin
        // address grows without wrap, bytes past the end are dropped
        waddr = int'(rx_addr) + int'(rx_wr_count);
        if (waddr < MemN) reg_mem[waddr] = b;
        rx_wr_count = rx_wr_count + 1;
        if (rx_wr_count == rx_size) rx_phase = scrb_pkg::PH_CMD;
      end
      default: rx_phase = scrb_pkg::PH_CMD;
    endcase
    return 1'b0;
  endfunction

  // drive one byte, called and returning at a falling edge
  task automatic send_rx_byte(input logic [7:0] b);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    if (!parse_rx_byte(b)) parsed_cnt++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic [7:0] cmd, input logic [15:0] size,
                             input logic [15:0] addr);
    send_rx_byte(cmd);
    send_rx_byte(size[15:8]);
    send_rx_byte(size[7:0]);
    send_rx_byte(addr[15:8]);
    send_rx_byte(addr[7:0]);
  endtask

  // finish whatever frame is open with short, harmless values
  task automatic close_open_frame();
    while (rx_phase != scrb_pkg::PH_CMD) begin
      case (rx_phase)
        scrb_pkg::PH_SIZE_HI: send_rx_byte(8'h00);
        scrb_pkg::PH_SIZE_LO: send_rx_byte(8'($urandom_range(0, 20)));
        default:              send_rx_byte(8'($urandom));
      endcase
    end
  endtask

  // receiver stalls in bursts
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // compare each reply beat with the oldest expected beat
  always @(posedge clk) begin : check_reply
    reply_beat_t exp_beat;
    if (rst_n && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected reply beat: read_byte=%02h is_last=%0b clipped=%0b",
               m_tdata, m_tlast, m_tuser);
        error_cnt++;
      end else begin
        exp_beat = reply_q.pop_front();
        if (m_tdata !== exp_beat.data) begin
          $error("read_byte: expected %02h, got %02h", exp_beat.data, m_tdata);
          error_cnt++;
        end
        if (m_tlast !== exp_beat.last) begin
          $error("is_last: expected %0b, got %0b", exp_beat.last, m_tlast);
          error_cnt++;
        end
        if (m_tuser !== exp_beat.clip) begin
          $error("clipped: expected %0b, got %0b", exp_beat.clip, m_tuser);
          error_cnt++;
        end
      end
    end
  end

  // write that runs past the memory end, extreme data values
  task automatic test_write_past_end();
    send_header(scrb_pkg::CMD_WRITE, 16'd5, 16'd14);
    send_rx_byte(8'hFF);
    send_rx_byte(8'h00);
    send_rx_byte(8'h81);
    send_rx_byte(8'h7E);
    send_rx_byte(8'hAA);
  endtask

  // clipped read at the end, empty read, read starting past the end
  task automatic test_read_edges();
    send_header(scrb_pkg::CMD_READ, 16'hFFFF, 16'd14);
    send_header(scrb_pkg::CMD_READ, 16'h0000, 16'h0000);
    send_header(scrb_pkg::CMD_READ, 16'd1, 16'hFFFF);
  endtask

  task automatic test_unknown_command();
    send_rx_byte(8'h54);
    send_rx_byte(8'h00);
  endtask

  // size zero write closes at its fifth byte, next byte is a fresh command
  task automatic test_empty_write();
    send_header(scrb_pkg::CMD_WRITE, 16'h0000, 16'd3);
    send_header(scrb_pkg::CMD_READ, 16'd2, 16'd2);
  endtask

  // mostly well formed frames with random content, some noise and cut headers
  task automatic test_random_frames(input int unsigned n_beats);
    int unsigned pick;
    int unsigned len;
    logic [15:0] size;
    logic [15:0] addr;
    logic [7:0]  noise;
    while (parsed_cnt < n_beats) begin
      // change idling now and then, including spells with none
      if ($urandom_range(0, 7) == 0) begin
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      addr = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        size = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 18));
        send_header(scrb_pkg::CMD_READ, size, addr);
      end else if (pick <= 7) begin
        size = 16'($urandom_range(0, 20));
        send_header(scrb_pkg::CMD_WRITE, size, addr);
        for (int unsigned i = 0; i < size; i++) send_rx_byte(8'($urandom));
      end else if (pick == 8) begin
        // bytes that are not commands are thrown away
        len = $urandom_range(1, 3);
        for (int unsigned i = 0; i < len; i++) begin
          noise = 8'($urandom);
          if (noise == scrb_pkg::CMD_READ || noise == scrb_pkg::CMD_WRITE) begin
            noise = ~noise[7:0] ^ 8'h01;
          end
          send_rx_byte(noise);
        end
      end else begin
        // header cut short, the following bytes become its tail
        send_rx_byte(($urandom_range(0, 1) == 0) ? scrb_pkg::CMD_READ : scrb_pkg::CMD_WRITE);
        len = $urandom_range(0, 3);
        for (int unsigned i = 0; i < len; i++) begin
          send_rx_byte((rx_phase == scrb_pkg::PH_SIZE_HI && rx_is_write) ? 8'h00
                                                                          : 8'($urandom));
        end
        close_open_frame();
      end
    end
  endtask

  // no idling: full write then back to back full reads with no backpressure
  task automatic test_full_rate();
    gap_pct   = 0;
    stall_pct = 0;
    send_header(scrb_pkg::CMD_WRITE, 16'd16, 16'd0);
    for (int unsigned i = 0; i < 16; i++) send_rx_byte(8'($urandom));
    repeat (3) send_header(scrb_pkg::CMD_READ, 16'd16, 16'd0);
    send_header(scrb_pkg::CMD_READ, 16'd17, 16'd0);
  endtask

  initial begin
    rst_n       = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    error_cnt   = 0;
    cycle_cnt   = 0;
    parsed_cnt  = 0;
    gap_pct     = 20;
    stall_pct   = 20;
    rx_phase    = scrb_pkg::PH_CMD;
    rx_is_write = 1'b0;
    rx_size     = '0;
    rx_addr     = '0;
    rx_wr_count = '0;
    for (int unsigned i = 0; i < MemN; i++) reg_mem[i] = 8'h00;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_write_past_end();
    test_read_edges();
    test_unknown_command();
    test_empty_write();
    test_random_frames(240);
    test_full_rate();

    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
